// File: rtl/fr_pkg.sv
// Shared constants for the Fresnel reflectance pipeline.
`default_nettype none
package fr_pkg;
    // Fixed-point ones
    localparam logic [15:0] ONE_Q12 = 16'd4096;
    localparam logic [14:0] ONE_Q14 = 15'd16384;
    localparam logic [28:0] ONE_Q28 = 29'd268435456;

    // Field and datapath widths
    localparam int VEC_W  = 16;
    localparam int IDX_W  = 16;
    localparam int KR_W   = 15;
    localparam int COS_W  = 29;   // clamped |cos|, Q.28 up to 1.0
    localparam int SQ_W   = 32;   // squared index, Q.24
    localparam int CT2_W  = 29;   // transmitted cos^2 and cos, Q.28 up to 1.0
    localparam int RAT_W  = 29;   // truncated Q.24 ratio terms
    localparam int DEN_W  = 30;   // ratio denominator
    localparam int RQ_W   = 31;   // ratio quotient, Q.30 up to 1.0
endpackage
`default_nettype wire

// File: rtl/fr_if.sv
// Valid/ready channel interfaces for the Fresnel reflectance block.
`default_nettype none
interface fr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] inc_x;
    logic signed [15:0] inc_y;
    logic signed [15:0] inc_z;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic        [15:0] refr_index;

    modport source (output valid, inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z, refr_index,
                    input ready);
    modport sink   (input valid, inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z, refr_index,
                    output ready);
endinterface

interface fr_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] reflectance;
    logic        total_internal;

    modport source (output valid, reflectance, total_internal, input ready);
    modport sink   (input valid, reflectance, total_internal, output ready);
endinterface
`default_nettype wire

// File: rtl/fresnel_reflectance.sv
// Pipeline from input accept to result valid: 6 + 29 divide + 29 root + 2 + 31 ratio
// divide + 2 stages.
// Throughput: one item per cycle while the output is not stalled; the long dividers and root are bit-per-stage.
// A stall at the output freezes every stage at once; nothing is lost or repeated.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
`default_nettype none
module fresnel_reflectance (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fr_in_if.sink     i_in,
    fr_out_if.source  o_out
);
    import fr_pkg::*;

    localparam int PAY_W = 1 + COS_W + 2 * IDX_W;

    logic w_en;

    // Stage 1: component products, index floor
    logic signed [31:0] r1_px, r1_py, r1_pz;
    logic [IDX_W-1:0]   r1_n;
    logic               r1_v;
    // Stage 2: clamped cosine and index swap
    logic [COS_W-1:0]   r2_c;
    logic [IDX_W-1:0]   r2_ei, r2_et;
    logic               r2_v;
    // Stage 3: squares
    logic [57:0]        r3_cc;
    logic [SQ_W-1:0]    r3_ei2, r3_et2;
    logic [COS_W-1:0]   r3_c;
    logic [IDX_W-1:0]   r3_ei, r3_et;
    logic               r3_v;
    // Stage 4: incident sine squared
    logic [28:0]        r4_s2;
    logic [SQ_W-1:0]    r4_ei2, r4_et2;
    logic [COS_W-1:0]   r4_c;
    logic [IDX_W-1:0]   r4_ei, r4_et;
    logic               r4_v;
    // Stage 5: ei2 * s2
    logic [60:0]        r5_lhs;
    logic [SQ_W-1:0]    r5_et2;
    logic [COS_W-1:0]   r5_c;
    logic [IDX_W-1:0]   r5_ei, r5_et;
    logic               r5_v;
    // Stage 6: TIR test and dividend
    logic [59:0]        r6_num;
    logic [SQ_W-1:0]    r6_et2;
    logic [COS_W-1:0]   r6_c;
    logic [IDX_W-1:0]   r6_ei, r6_et;
    logic               r6_tir;
    logic               r6_v;

    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // Stage 1
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_px <= i_in.inc_x * i_in.nrm_x;
            r1_py <= i_in.inc_y * i_in.nrm_y;
            r1_pz <= i_in.inc_z * i_in.nrm_z;
            r1_n  <= (i_in.refr_index < ONE_Q12) ? ONE_Q12 : i_in.refr_index;
        end
    end

    // Stage 2: dot product, clamp, swap when leaving the medium
    logic signed [32:0] w_dot;
    logic [32:0]        w_abs;
    logic               w_leave;
    assign w_dot   = 33'(r1_px) + 33'(r1_py) + 33'(r1_pz);
    assign w_abs   = w_dot[32] ? 33'(-w_dot) : 33'(w_dot);
    assign w_leave = (w_dot > 33'sd0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_c  <= (w_abs > 33'(ONE_Q28)) ? ONE_Q28 : w_abs[COS_W-1:0];
            r2_ei <= w_leave ? r1_n : ONE_Q12;
            r2_et <= w_leave ? ONE_Q12 : r1_n;
        end
    end

    // Stage 3
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_cc  <= 58'(r2_c) * 58'(r2_c);
            r3_ei2 <= SQ_W'(r2_ei) * SQ_W'(r2_ei);
            r3_et2 <= SQ_W'(r2_et) * SQ_W'(r2_et);
            r3_c   <= r2_c;
            r3_ei  <= r2_ei;
            r3_et  <= r2_et;
        end
    end

    // Stage 4: s2 = (2^56 - c^2) >> 28
    logic [56:0] w_s2full;
    assign w_s2full = (57'(1) << 56) - 57'(r3_cc);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_s2  <= w_s2full[56:28];
            r4_ei2 <= r3_ei2;
            r4_et2 <= r3_et2;
            r4_c   <= r3_c;
            r4_ei  <= r3_ei;
            r4_et  <= r3_et;
        end
    end

    // Stage 5
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_lhs <= 61'(r4_ei2) * 61'(r4_s2);
            r5_et2 <= r4_et2;
            r5_c   <= r4_c;
            r5_ei  <= r4_ei;
            r5_et  <= r4_et;
        end
    end

    // Stage 6: total internal reflection when ei2*s2 >= et2*2^28
    logic [59:0] w_rhs;
    logic        w_tir;
    assign w_rhs = {r5_et2, 28'd0};
    assign w_tir = (r5_lhs >= {1'b0, w_rhs});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_num <= w_tir ? 60'd0 : (w_rhs - r5_lhs[59:0]);
            r6_tir <= w_tir;
            r6_et2 <= r5_et2;
            r6_c   <= r5_c;
            r6_ei  <= r5_ei;
            r6_et  <= r5_et;
        end
    end

    // Valid chain for stages 1 to 6
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // Transmitted cos^2 = (rhs - lhs) / et2, up to 1.0 at normal incidence
    logic             w_d1_v;
    logic [CT2_W-1:0] w_ct2;
    logic [PAY_W-1:0] w_d1_pay;

    fr_div #(.QW(CT2_W), .DW(SQ_W), .PW(PAY_W)) u_ct2_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r6_v),
        .i_num   ({1'b0, r6_num}),
        .i_den   (r6_et2),
        .i_pay   ({r6_tir, r6_c, r6_ei, r6_et}),
        .o_vld   (w_d1_v),
        .o_quo   (w_ct2),
        .o_pay   (w_d1_pay)
    );

    // Transmitted cosine = sqrt(cos^2 * 2^28)
    logic             w_sq_v;
    logic [CT2_W-1:0] w_cost;
    logic [PAY_W-1:0] w_sq_pay;

    fr_sqrt #(.RW(CT2_W), .PW(PAY_W)) u_cost_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_d1_v),
        .i_val   ({1'b0, w_ct2, 28'd0}),
        .i_pay   (w_d1_pay),
        .o_vld   (w_sq_v),
        .o_root  (w_cost),
        .o_pay   (w_sq_pay)
    );

    logic             w_q_tir;
    logic [COS_W-1:0] w_q_c;
    logic [IDX_W-1:0] w_q_ei, w_q_et;
    assign {w_q_tir, w_q_c, w_q_ei, w_q_et} = w_sq_pay;

    // Stage 7: index-cosine products truncated to Q.24
    logic [44:0]      w_pas, w_pbs, w_pap, w_pbp;
    logic [RAT_W-1:0] r7_as, r7_bs, r7_ap, r7_bp;
    logic             r7_tir, r7_v;
    assign w_pas = 45'(w_q_et) * 45'(w_q_c);
    assign w_pbs = 45'(w_q_ei) * 45'(w_cost);
    assign w_pap = 45'(w_q_ei) * 45'(w_q_c);
    assign w_pbp = 45'(w_q_et) * 45'(w_cost);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_as  <= w_pas[44:16];
            r7_bs  <= w_pbs[44:16];
            r7_ap  <= w_pap[44:16];
            r7_bp  <= w_pbp[44:16];
            r7_tir <= w_q_tir;
        end
    end

    // Stage 8: ratio numerator and denominator
    logic [DEN_W-1:0]   r8_ds, r8_dp;
    logic [RAT_W-1:0]   r8_ns, r8_np;
    logic               r8_zs, r8_zp, r8_tir, r8_v;
    logic [DEN_W-1:0]   w_ds, w_dp;
    assign w_ds = DEN_W'(r7_as) + DEN_W'(r7_bs);
    assign w_dp = DEN_W'(r7_ap) + DEN_W'(r7_bp);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_ds  <= w_ds;
            r8_dp  <= w_dp;
            r8_ns  <= (r7_as > r7_bs) ? (r7_as - r7_bs) : (r7_bs - r7_as);
            r8_np  <= (r7_ap > r7_bp) ? (r7_ap - r7_bp) : (r7_bp - r7_ap);
            r8_zs  <= (w_ds == '0);
            r8_zp  <= (w_dp == '0);
            r8_tir <= r7_tir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else if (w_en) begin
            r7_v <= w_sq_v;
            r8_v <= r7_v;
        end
    end

    // Ratio magnitudes |a-b| * 2^30 / (a+b)
    logic            w_rs_v, w_rp_v;
    logic [RQ_W-1:0] w_rs, w_rp;
    logic [1:0]      w_rs_pay;
    logic            w_rp_pay;

    fr_div #(.QW(RQ_W), .DW(DEN_W), .PW(2)) u_rs_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r8_v),
        .i_num   ({2'd0, r8_ns, 30'd0}),
        .i_den   (r8_ds),
        .i_pay   ({r8_tir, r8_zs}),
        .o_vld   (w_rs_v),
        .o_quo   (w_rs),
        .o_pay   (w_rs_pay)
    );

    fr_div #(.QW(RQ_W), .DW(DEN_W), .PW(1)) u_rp_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r8_v),
        .i_num   ({2'd0, r8_np, 30'd0}),
        .i_den   (r8_dp),
        .i_pay   (r8_zp),
        .o_vld   (w_rp_v),
        .o_quo   (w_rp),
        .o_pay   (w_rp_pay)
    );

    // Stage 9: square the ratios; a vanishing denominator counts as 1.0
    localparam logic [RQ_W-1:0] ONE_Q30 = RQ_W'(1) << 30;
    logic [RQ_W-1:0] w_rs_f, w_rp_f;
    logic [61:0]     r9_rs2, r9_rp2;
    logic            r9_tir, r9_v;
    assign w_rs_f = w_rs_pay[0] ? ONE_Q30 : w_rs;
    assign w_rp_f = w_rp_pay    ? ONE_Q30 : w_rp;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_rs2 <= 62'(w_rs_f) * 62'(w_rs_f);
            r9_rp2 <= 62'(w_rp_f) * 62'(w_rp_f);
            r9_tir <= w_rs_pay[1];
        end
    end

    // Stage 10: mean, round to Q.14, saturate (1.0 on total internal reflection); output register
    logic [62:0] w_sum;
    logic [15:0] w_kr;
    logic [KR_W-1:0] r_okr;
    logic            r_otir, r_ov;
    assign w_sum = 63'(r9_rs2) + 63'(r9_rp2) + (63'(1) << 46);
    assign w_kr  = w_sum[62:47];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_otir <= r9_tir;
            if (r9_tir || (w_kr > 16'(ONE_Q14))) begin
                r_okr <= ONE_Q14;
            end else begin
                r_okr <= w_kr[KR_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r9_v <= w_rs_v & w_rp_v;
            r_ov <= r9_v;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.reflectance    = r_okr;
    assign o_out.total_internal = r_otir;

    // Checks
    a_tir_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_otir) |-> (r_okr == ONE_Q14))
        else $error("total internal reflection without full reflectance");

    a_kr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_okr <= ONE_Q14))
        else $error("reflectance above one");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rs_v == w_rp_v)
        else $error("ratio dividers out of step");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r9_rs2) && $stable(r9_v)))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire

// File: rtl/fr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module fr_div #(
    parameter int QW = 28,
    parameter int DW = 32,
    parameter int PW = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire logic [QW+DW-1:0]   i_num,
    input  wire logic [DW-1:0]      i_den,
    input  wire logic [PW-1:0]      i_pay,
    output logic                    o_vld,
    output logic [QW-1:0]           o_quo,
    output logic [PW-1:0]           o_pay
);
    localparam int RW = QW + DW;

    logic [RW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];
    logic [PW-1:0] r_pay [QW];
    logic          r_vld [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BI = QW - 1 - k;
        logic [RW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_quo;
        logic [PW-1:0] w_pay;
        logic          w_vld;
        logic [RW-1:0] w_trial;
        logic          w_hit;

        if (k == 0) begin : g_first
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
            assign w_pay = i_pay;
            assign w_vld = i_vld;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_quo = r_quo[k-1];
            assign w_pay = r_pay[k-1];
            assign w_vld = r_vld[k-1];
        end

        // Trial subtract of the shifted divisor
        assign w_trial = RW'(w_den) << BI;
        assign w_hit   = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_hit ? (w_rem - w_trial) : w_rem;
                r_den[k] <= w_den;
                r_quo[k] <= w_quo | (QW'(w_hit) << BI);
                r_pay[k] <= w_pay;
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_quo[QW-1];
    assign o_pay = r_pay[QW-1];
endmodule
`default_nettype wire

// File: rtl/fr_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none
module fr_sqrt #(
    parameter int RW = 28,
    parameter int PW = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [2*RW-1:0]   i_val,
    input  wire logic [PW-1:0]     i_pay,
    output logic                   o_vld,
    output logic [RW-1:0]          o_root,
    output logic [PW-1:0]          o_pay
);
    localparam int VW = 2 * RW;

    logic [VW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [PW-1:0] r_pay  [RW];
    logic          r_vld  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int BI = RW - 1 - k;
        logic [VW-1:0] w_rem;
        logic [RW-1:0] w_root;
        logic [PW-1:0] w_pay;
        logic          w_vld;
        logic [VW:0]   w_t;
        logic          w_hit;

        if (k == 0) begin : g_first
            assign w_rem  = i_val;
            assign w_root = '0;
            assign w_pay  = i_pay;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_pay  = r_pay[k-1];
            assign w_vld  = r_vld[k-1];
        end

        // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
        assign w_t   = ((VW+1)'(w_root) << (BI + 1)) | ((VW+1)'(1) << (2 * BI));
        assign w_hit = ({1'b0, w_rem} >= w_t);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_hit ? (w_rem - w_t[VW-1:0]) : w_rem;
                r_root[k] <= w_root | (RW'(w_hit) << BI);
                r_pay[k]  <= w_pay;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_pay  = r_pay[RW-1];
endmodule
`default_nettype wire
